### hw/rtl/crpc_pkg.sv
// ----------------------------------------------------------------------------
// Cycle rate product cache package
// Shared request and result types, sizes and command codes.
// ----------------------------------------------------------------------------
package crpc_pkg;

	localparam int MAX_PAIRS  = 64;
	localparam int MAX_CYCLES = 64;
	localparam int MAX_LEGS   = 4;

	typedef enum logic [1:0] {
		CMD_UPDATE    = 2'd0,
		CMD_SET_LEG   = 2'd1,
		CMD_SET_COUNT = 2'd2,
		CMD_NONE      = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [5:0]  pair_index;
		logic [31:0] rate_value;
		logic [5:0]  cycle_index;
		logic [1:0]  leg_slot;
		logic [2:0]  leg_count;
	} req_t;

	typedef struct packed {
		logic [5:0]  cycle_number;
		logic [31:0] profit_product;
		logic        profit_known;
		logic        overflowed;
		logic        last_of_run;
	} res_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_MUL  = 2'd2,
		ST_EMIT = 2'd3
	} state_t;

endpackage

### hw/rtl/crpc_cell.sv
// ----------------------------------------------------------------------------
// Cycle rate product cache cell
// Holds one cycle's legs and count and rotates them along the ring.
// ----------------------------------------------------------------------------
module crpc_cell #(
	parameter int MAX_LEGS = 4,
	parameter int PW = 6,
	parameter int CW = 3,
	parameter int SW = 2
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     shift,
	input  logic                     wr_leg,
	input  logic                     wr_cnt,
	input  logic [SW-1:0]            slot,
	input  logic [PW-1:0]            pair,
	input  logic [CW-1:0]            cnt,
	input  logic [MAX_LEGS*PW-1:0]   legs_in,
	input  logic [CW-1:0]            cnt_in,
	output logic [MAX_LEGS*PW-1:0]   legs_out,
	output logic [CW-1:0]            cnt_out
);
	logic [MAX_LEGS*PW-1:0] legs_q;
	logic [CW-1:0]          cnt_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			legs_q <= legs_in;
		end else if (wr_leg) begin
			legs_q[slot*PW +: PW] <= pair;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (shift) begin
			cnt_q <= cnt_in;
		end else if (wr_cnt) begin
			cnt_q <= cnt;
		end
	end

	assign legs_out = legs_q;
	assign cnt_out  = cnt_q;
endmodule

### hw/rtl/cycle_rate_product_cache.sv
// ----------------------------------------------------------------------------
// Cycle rate product cache
// A ring of cells, one per cycle, each holding that cycle's legs and count.
// ----------------------------------------------------------------------------
// A set-leg or set-count request is written straight into its cell and busy
// stays low. A rate update rotates the ring once: each of the MAX_CYCLES cells
// passes the head, and a cell whose cycle holds the pair stops there while its
// legs are multiplied in turn (legs stop at the first unset rate) and is then
// emitted; busy stays high until the scan ends. Each result is shown one step
// late, when the next hit finishes or the scan ends, so the last result of an
// update, marked by last_of_run, appears in the first cycle in which busy is
// low. Results cannot be stalled.
module cycle_rate_product_cache (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  crpc_pkg::req_t  request,
	output logic            busy,
	output logic            done,
	output crpc_pkg::res_t  result
);
	import crpc_pkg::*;

	localparam int PW = 6;
	localparam int CW = 3;
	localparam int SW = 2;
	localparam int LW = MAX_LEGS * PW;
	localparam int CIW = (MAX_CYCLES > 1) ? $clog2(MAX_CYCLES) : 1;
	localparam int PIW = $clog2(MAX_PAIRS);
	localparam int KW = $clog2(MAX_LEGS + 1);

	logic [LW-1:0] legs_w [MAX_CYCLES];
	logic [CW-1:0] cnt_w  [MAX_CYCLES];
	logic [31:0] rate_mem [MAX_PAIRS];
	logic [MAX_PAIRS-1:0] rate_set_q;

	state_t state_q, state_d;
	logic [CIW:0] pos_q;
	logic [KW-1:0] k_q;
	logic [PW-1:0] upd_pair_q;
	logic [31:0] prod_q;
	logic sat_q, known_q, any_q, last_seen_q;
	res_t res_q;
	res_t hold_q;
	logic done_q;
	logic shift;
	logic accept;
	logic hit;
	logic [KW-1:0] hcnt;
	logic [PW-1:0] leg_pair;
	logic [SW-1:0] rd_slot;
	logic [PW-1:0] rd_pair;
	logic [31:0] rate_rd_q;
	logic [63:0] mul;
	logic [CW-1:0] cnt_sat;

	assign accept = start && !busy;
	assign cnt_sat = (request.leg_count > CW'(MAX_LEGS)) ? CW'(MAX_LEGS) : request.leg_count;

	for (genvar i = 0; i < MAX_CYCLES; i++) begin : g_cell
		logic wl, wc;
		assign wl = accept && request.command == CMD_SET_LEG
			&& 32'(request.cycle_index) == i && 32'(request.leg_slot) < MAX_LEGS
			&& 32'(request.pair_index) < MAX_PAIRS;
		assign wc = accept && request.command == CMD_SET_COUNT
			&& 32'(request.cycle_index) == i;
		crpc_cell #(.MAX_LEGS(MAX_LEGS), .PW(PW), .CW(CW), .SW(SW)) u_cell (
			.clk(clk), .arst_n(arst_n), .shift(shift),
			.wr_leg(wl), .wr_cnt(wc), .slot(request.leg_slot),
			.pair(request.pair_index), .cnt(cnt_sat),
			.legs_in(legs_w[(i + 1) % MAX_CYCLES]),
			.cnt_in(cnt_w[(i + 1) % MAX_CYCLES]),
			.legs_out(legs_w[i]), .cnt_out(cnt_w[i])
		);
	end

	assign hcnt = KW'(cnt_w[0]);

	always_comb begin
		hit = 1'b0;
		for (int k = 0; k < MAX_LEGS; k++) begin
			if (KW'(k) < hcnt && legs_w[0][k*PW +: PW] == upd_pair_q) hit = 1'b1;
		end
	end

	assign leg_pair = legs_w[0][k_q[SW-1:0]*PW +: PW];
	assign rd_slot = (state_q == ST_MUL) ? k_q[SW-1:0] + 1'b1 : '0;
	assign rd_pair = legs_w[0][rd_slot*PW +: PW];
	assign mul = 64'(prod_q) * 64'(rate_rd_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (accept && request.command == CMD_UPDATE
				&& 32'(request.pair_index) < MAX_PAIRS) state_d = ST_SCAN;
			ST_SCAN: begin
				if (pos_q == (CIW+1)'(MAX_CYCLES)) state_d = ST_IDLE;
				else if (hit) state_d = ST_MUL;
			end
			ST_MUL: if (k_q == hcnt || !known_q) state_d = ST_EMIT;
			ST_EMIT: state_d = ST_SCAN;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		shift = (state_q == ST_SCAN && !hit && pos_q != (CIW+1)'(MAX_CYCLES))
			|| state_q == ST_EMIT;
		busy = state_q != ST_IDLE;
	end

	always_ff @(posedge clk) begin
		if (accept && request.command == CMD_UPDATE && 32'(request.pair_index) < MAX_PAIRS)
			rate_mem[request.pair_index[PIW-1:0]] <= request.rate_value;
		rate_rd_q <= rate_mem[rd_pair[PIW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rate_set_q <= '0;
			pos_q <= '0;
			k_q <= '0;
			upd_pair_q <= '0;
			prod_q <= '0;
			sat_q <= 1'b0;
			known_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					pos_q <= '0;
					if (accept && request.command == CMD_UPDATE
						&& 32'(request.pair_index) < MAX_PAIRS) begin
						rate_set_q[request.pair_index[PIW-1:0]] <= 1'b1;
						upd_pair_q <= request.pair_index;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						k_q <= '0;
						prod_q <= 32'h0001_0000;
						sat_q <= 1'b0;
						known_q <= 1'b1;
					end else if (pos_q != (CIW+1)'(MAX_CYCLES)) begin
						pos_q <= pos_q + 1'b1;
					end
				end
				ST_MUL: begin
					if (k_q != hcnt && known_q) begin
						k_q <= k_q + 1'b1;
						if (32'(leg_pair) >= MAX_PAIRS || !rate_set_q[leg_pair[PIW-1:0]]) begin
							known_q <= 1'b0;
						end else if (!sat_q) begin
							if (mul[63:48] != '0) begin
								prod_q <= '1;
								sat_q <= 1'b1;
							end else begin
								prod_q <= mul[47:16];
							end
						end
					end
				end
				ST_EMIT: begin
					pos_q <= pos_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Results are held one slot so the last of a run can be marked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_seen_q <= 1'b0;
			done_q <= 1'b0;
			any_q <= 1'b0;
			hold_q <= '0;
			res_q <= '0;
		end else begin
			last_seen_q <= 1'b0;
			done_q <= 1'b0;
			if (state_q == ST_EMIT) begin
				if (any_q) begin
					done_q <= 1'b1;
					res_q <= hold_q;
				end
				any_q <= 1'b1;
				hold_q.cycle_number <= 6'(pos_q);
				hold_q.profit_product <= known_q ? prod_q : '0;
				hold_q.profit_known <= known_q;
				hold_q.overflowed <= known_q && sat_q;
				hold_q.last_of_run <= 1'b0;
			end else if (state_q == ST_SCAN && pos_q == (CIW+1)'(MAX_CYCLES) && any_q) begin
				done_q <= 1'b1;
				res_q <= hold_q;
				last_seen_q <= 1'b1;
				any_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	always_comb begin
		result = res_q;
		result.last_of_run = last_seen_q;
	end
endmodule

### hw/rtl/crpc_checker.sv
// ----------------------------------------------------------------------------
// Cycle rate product cache checker
// Port-level properties of the busy, done and result interface.
// ----------------------------------------------------------------------------
module crpc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           busy,
	input logic           done,
	input crpc_pkg::res_t result
);
	a_unknown_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.profit_known |-> result.profit_product == '0 && !result.overflowed)
		else $error("unknown product not zero");
	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.overflowed |-> result.profit_product == '1)
		else $error("overflow without saturation");
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.last_of_run |-> busy)
		else $error("result outside update");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.last_of_run |=> !done)
		else $error("result after last");
endmodule

bind cycle_rate_product_cache crpc_checker u_crpc_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy),
	.done(done), .result(result)
);
